/* rtl/core/token_bucket_rate_limiter_core_defines.svh */
// Assertion macros for the token bucket rate limiter core.
// Depends on nothing; included by the top level.
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TBRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbrl: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TBRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbrl: next-cycle check failed");

`endif

/* rtl/core/tbrl_pkg.sv */
// Shared types and constants for the token bucket rate limiter core.
// Depends on nothing.
package tbrl_pkg;

    localparam int TOKEN_W      = 16;
    localparam int TIME_W       = 32;
    localparam int SLOT_IN_W    = 8;
    localparam int PROD_W       = TIME_W + TOKEN_W;
    localparam int CNT_W        = $clog2(PROD_W);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DEF_USER_SLOTS = 256;

    localparam logic [TOKEN_W-1:0]   MAX_TOKENS_RST = 16'd50;
    localparam logic [TOKEN_W-1:0]   WINDOW_RST     = 16'd60;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;
    localparam logic                 CMD_RESET      = 1'b1;

    typedef struct packed {
        logic load;
        logic read;
        logic calc;
        logic div_step;
        logic update;
    } tbrl_cmd_t;

    typedef struct packed {
        logic bypass;
        logic div_last;
    } tbrl_status_t;

endpackage

/* rtl/core/tbrl_ctrl.sv */
// Controller state machine for the token bucket rate limiter core.
// Depends on tbrl_pkg; drives tbrl_datapath through command and status structs.
module tbrl_ctrl
    import tbrl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  tbrl_status_t status,
    output tbrl_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_UPD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = status.bypass ? S_UPD : S_MUL;
            end
            S_MUL:
            begin
                cmd.calc   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/tbrl_datapath.sv */
// Datapath for the token bucket rate limiter core: config registers, bucket
// store, multiplier, serial divider and refill logic. Depends on tbrl_pkg.
module tbrl_datapath
    import tbrl_pkg::*;
#(
    parameter int USER_SLOTS = DEF_USER_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbrl_cmd_t             cmd,
    output tbrl_status_t          status,
    input  logic                  command,
    input  logic [SLOT_IN_W-1:0]  user_slot,
    input  logic [TIME_W-1:0]     timestamp,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  allowed,
    output logic [TOKEN_W-1:0]    tokens_left
);

    localparam int SLOT_SPAN = 1 << SLOT_IN_W;
    localparam int DEPTH     = (USER_SLOTS > SLOT_SPAN) ? SLOT_SPAN : USER_SLOTS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W     = TIME_W + TOKEN_W;

    logic [TOKEN_W-1:0] max_tokens_reg;
    logic [TOKEN_W-1:0] window_seconds_reg;

    logic               cmd_reg;
    logic               in_range_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [MEM_W-1:0]   mem [DEPTH];
    logic [MEM_W-1:0]   rd_data_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic               hit_reg;

    logic [TOKEN_W-1:0] tok_reg;
    logic [TIME_W-1:0]  last_reg;
    logic [PROD_W-1:0]  dvd_reg;
    logic [TOKEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               done_reg;
    logic               allowed_reg;
    logic [TOKEN_W-1:0] tokens_left_reg;

    logic [31:0]        slot_ext;
    logic [TOKEN_W-1:0] win;
    logic [TOKEN_W-1:0] base_tok;
    logic [TIME_W-1:0]  base_time;
    logic [TIME_W-1:0]  elapsed;
    logic [TOKEN_W:0]   rem_shift;
    logic               rem_ge;
    logic               fresh_pos;
    logic [TOKEN_W:0]   sum;
    logic [TOKEN_W-1:0] refilled;
    logic [TOKEN_W-1:0] new_tok;
    logic [TIME_W-1:0]  new_time;
    logic               grant;
    logic [TOKEN_W-1:0] final_tok;

    assign slot_ext = 32'(user_slot);
    assign win      = (window_seconds_reg == '0) ? TOKEN_W'(1) : window_seconds_reg;

    assign status.bypass   = (cmd_reg == CMD_RESET) || !in_range_reg;
    assign status.div_last = (cnt_reg == CNT_W'(PROD_W - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tokens_reg     <= MAX_TOKENS_RST;
            window_seconds_reg <= WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MAX_TOKENS)
            begin
                max_tokens_reg <= cfg_data;
            end
            else if (cfg_index == CFG_WINDOW)
            begin
                window_seconds_reg <= cfg_data;
            end
        end
    end

    // Bucket store: time and tokens per slot, read and written at one address
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= mem[addr_reg];
        end
        if (cmd.update && !status.bypass)
        begin
            mem[addr_reg] <= {new_time, final_tok};
        end
    end

    // Refill arithmetic
    always_comb
    begin
        base_tok  = hit_reg ? rd_data_reg[TOKEN_W-1:0] : max_tokens_reg;
        base_time = hit_reg ? rd_data_reg[MEM_W-1:TOKEN_W] : now_reg;
        elapsed   = (now_reg >= base_time) ? (now_reg - base_time) : '0;

        rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
        rem_ge    = (rem_shift >= {1'b0, win});

        fresh_pos = |dvd_reg;
        sum       = {1'b0, tok_reg} + {1'b0, dvd_reg[TOKEN_W-1:0]};
        if ((|dvd_reg[PROD_W-1:TOKEN_W]) || (sum > {1'b0, max_tokens_reg}))
        begin
            refilled = max_tokens_reg;
        end
        else
        begin
            refilled = sum[TOKEN_W-1:0];
        end
        new_tok   = fresh_pos ? refilled : tok_reg;
        new_time  = fresh_pos ? now_reg : last_reg;
        grant     = (new_tok != '0);
        final_tok = grant ? (new_tok - TOKEN_W'(1)) : new_tok;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.update && in_range_reg)
        begin
            valid_next[addr_reg] = (cmd_reg != CMD_RESET);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= cmd.update;
            if (cmd.calc)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= command;
            in_range_reg <= (slot_ext < 32'(USER_SLOTS));
            addr_reg     <= slot_ext[ADDR_W-1:0];
            now_reg      <= timestamp;
        end
        if (cmd.read)
        begin
            hit_reg <= valid_reg[addr_reg];
        end
        if (cmd.calc)
        begin
            tok_reg  <= base_tok;
            last_reg <= base_time;
            dvd_reg  <= PROD_W'(elapsed) * max_tokens_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? TOKEN_W'(rem_shift - {1'b0, win}) : rem_shift[TOKEN_W-1:0];
            dvd_reg <= {dvd_reg[PROD_W-2:0], rem_ge};
        end
        if (cmd.update)
        begin
            allowed_reg     <= !status.bypass && grant;
            tokens_left_reg <= status.bypass ? '0 : final_tok;
        end
    end

    assign done        = done_reg;
    assign allowed     = allowed_reg;
    assign tokens_left = tokens_left_reg;

endmodule

/* rtl/core/token_bucket_rate_limiter_core.sv */
// Top level of the token bucket rate limiter core.
// Depends on tbrl_pkg, tbrl_ctrl, tbrl_datapath and the assertion macro header.
//
// Usage:
//   Items enter on start/busy: an item (command, user_slot, timestamp) is taken
//   at a clock edge with start high and busy low. busy stays high while the
//   item is worked on.
//   Each item gives one result: done is high for exactly one cycle with
//   allowed and tokens_left valid in that cycle. The receiver cannot stall.
//   A request item passes through one store read, one multiply, 48 steps of
//   the serial divider over the 48-bit product of elapsed time and capacity,
//   and one update; the divider is the longest part. A new item is not taken
//   until the current one is done. A reset command or an out-of-range slot skips multiply and divide.
//   busy falls in the cycle that shows done, so a new item may start then.
//   Configuration: cfg_valid with cfg_index and cfg_data writes a register;
//   cfg_ready is always high. Write only while busy is low.
//   Reset: all slots read as invalid, capacity 50, window 60 seconds.
`include "token_bucket_rate_limiter_core_defines.svh"

module token_bucket_rate_limiter_core
    import tbrl_pkg::*;
#(
    parameter int USER_SLOTS = DEF_USER_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [SLOT_IN_W-1:0]  user_slot,
    input  logic [TIME_W-1:0]     timestamp,
    output logic                  done,
    output logic                  allowed,
    output logic [TOKEN_W-1:0]    tokens_left,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tbrl_cmd_t    cmd;
    tbrl_status_t status;

    assign cfg_ready = 1'b1;

    tbrl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tbrl_datapath #(
        .USER_SLOTS (USER_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .command     (command),
        .user_slot   (user_slot),
        .timestamp   (timestamp),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .allowed     (allowed),
        .tokens_left (tokens_left)
    );

    `TBRL_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `TBRL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `TBRL_ASSERT_NOW(a_done_after_work, clk, rst_n, done, $past(busy))
    `TBRL_ASSERT_NOW(a_bypass_no_grant, clk, rst_n, done && $past(status.bypass), !allowed)

endmodule

/* tb/tb_top.sv */
// Testbench for token_bucket_rate_limiter_core: directed and random items checked
// against a bucket predictor kept inside this file.
// Depends on tbrl_pkg and the core RTL.
module tb_top;
    import tbrl_pkg::*;

    localparam logic                 CMD_REQUEST = ~CMD_RESET;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3  = 2'd3;

    typedef struct {
        logic               allowed;
        logic [TOKEN_W-1:0] tokens_left;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  command;
    logic [SLOT_IN_W-1:0]  user_slot;
    logic [TIME_W-1:0]     timestamp;
    logic                  done;
    logic                  allowed;
    logic [TOKEN_W-1:0]    tokens_left;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                 bucket_live [DEF_USER_SLOTS];
    logic [TOKEN_W-1:0] bucket_level [DEF_USER_SLOTS];
    logic [TIME_W-1:0]  refill_at [DEF_USER_SLOTS];
    logic [TOKEN_W-1:0] bucket_cap = MAX_TOKENS_RST;
    logic [TOKEN_W-1:0] bucket_window = WINDOW_RST;

    verdict_t expected_verdicts [$];
    int unsigned mismatches = 0;

    token_bucket_rate_limiter_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .user_slot   (user_slot),
        .timestamp   (timestamp),
        .done        (done),
        .allowed     (allowed),
        .tokens_left (tokens_left),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic verdict_t admit_item(input logic cmd, input logic [SLOT_IN_W-1:0] slot,
                                            input logic [TIME_W-1:0] now);
        verdict_t               v;
        logic [TIME_W-1:0]      elapsed;
        logic [PROD_W-1:0]      product;
        logic [PROD_W-1:0]      fresh;
        logic [TOKEN_W-1:0]     win;
        logic [PROD_W:0]        level;
        v.allowed     = 1'b0;
        v.tokens_left = '0;
        if (cmd == CMD_RESET)
        begin
            bucket_live[slot] = 1'b0;
        end
        else
        begin
            if (!bucket_live[slot])
            begin
                bucket_live[slot]  = 1'b1;
                bucket_level[slot] = bucket_cap;
                refill_at[slot]    = now;
            end
            elapsed = (now >= refill_at[slot]) ? now - refill_at[slot] : '0;
            win     = (bucket_window == '0) ? 16'd1 : bucket_window;
            product = elapsed * bucket_cap;
            fresh   = product / win;
            level   = bucket_level[slot];
            if (fresh != '0)
            begin
                level = level + fresh;
                if (level > bucket_cap)
                    level = bucket_cap;
                refill_at[slot] = now;
            end
            if (level != '0)
            begin
                level     = level - 1'b1;
                v.allowed = 1'b1;
            end
            bucket_level[slot] = level[TOKEN_W-1:0];
            v.tokens_left      = level[TOKEN_W-1:0];
        end
        return v;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                note_failure($sformatf("unexpected result: allowed=%0b tokens_left=%0d",
                                       allowed, tokens_left));
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (allowed !== exp_v.allowed || tokens_left !== exp_v.tokens_left)
                    note_failure($sformatf(
                        "mismatch: allowed exp %0b got %0b, tokens_left exp %0d got %0d",
                        exp_v.allowed, allowed, exp_v.tokens_left, tokens_left));
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [SLOT_IN_W-1:0] slot,
                             input logic [TIME_W-1:0] ts);
        @(negedge clk);
        start     = 1'b1;
        command   = cmd;
        user_slot = slot;
        timestamp = ts;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_verdicts.push_back(admit_item(cmd, slot, ts));
    endtask

    task automatic idle_for(input int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_verdicts.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MAX_TOKENS)
            bucket_cap = val;
        else if (idx == CFG_WINDOW)
            bucket_window = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_fresh_slot();
        send_item(CMD_REQUEST, 8'd0, 32'd100);
        send_item(CMD_REQUEST, 8'd0, 32'd100);
        send_item(CMD_REQUEST, 8'd0, 32'd101);
        send_item(CMD_REQUEST, 8'd0, 32'd160);
    endtask

    task automatic test_reset_command();
        send_item(CMD_RESET, 8'd0, 32'd160);
        send_item(CMD_REQUEST, 8'd0, 32'd0);
        send_item(CMD_RESET, 8'd255, 32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        send_item(CMD_REQUEST, 8'd255, 32'hFFFF_FFFF);
        send_item(CMD_REQUEST, 8'd255, 32'd0);
        send_item(CMD_REQUEST, 8'd128, 32'd0);
        send_item(CMD_REQUEST, 8'd128, 32'hFFFF_FFFF);
    endtask

    task automatic test_window_extremes();
        write_reg(CFG_MAX_TOKENS, 16'd5);
        write_reg(CFG_WINDOW, 16'd0);
        send_item(CMD_REQUEST, 8'd1, 32'd10);
        send_item(CMD_REQUEST, 8'd1, 32'd11);
        write_reg(CFG_MAX_TOKENS, 16'hFFFF);
        write_reg(CFG_WINDOW, 16'hFFFF);
        send_item(CMD_REQUEST, 8'd2, 32'd0);
        send_item(CMD_REQUEST, 8'd2, 32'd1);
    endtask

    task automatic test_zero_capacity();
        write_reg(CFG_MAX_TOKENS, 16'd0);
        write_reg(CFG_WINDOW, 16'd60);
        send_item(CMD_REQUEST, 8'd3, 32'd5);
        send_item(CMD_REQUEST, 8'd3, 32'd1000);
    endtask

    task automatic test_capacity_lowered();
        write_reg(CFG_MAX_TOKENS, 16'd20);
        send_item(CMD_REQUEST, 8'd4, 32'd50);
        write_reg(CFG_MAX_TOKENS, 16'd5);
        send_item(CMD_REQUEST, 8'd4, 32'd50);
        send_item(CMD_REQUEST, 8'd4, 32'd1000);
    endtask

    task automatic test_unused_registers();
        write_reg(CFG_SPARE2, 16'($urandom));
        write_reg(CFG_SPARE3, 16'($urandom));
        send_item(CMD_REQUEST, 8'd4, 32'd1000);
    endtask

    task automatic run_traffic(input int unsigned cap, input int unsigned win, input int n);
        int unsigned          clock_s;
        int unsigned          hot_base;
        int unsigned          hot_count;
        int unsigned          burst_left;
        int unsigned          span;
        int unsigned          r;
        logic                 cmd;
        logic [SLOT_IN_W-1:0] slot;
        logic [TIME_W-1:0]    ts;
        write_reg(CFG_MAX_TOKENS, cap[TOKEN_W-1:0]);
        write_reg(CFG_WINDOW, win[TOKEN_W-1:0]);
        clock_s    = $urandom;
        hot_base   = $urandom_range(0, 255);
        hot_count  = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
        span       = (win == 0) ? 2 : 2 * win;
        for (int k = 0; k < n; k++)
        begin
            r    = $urandom_range(0, 99);
            cmd  = CMD_REQUEST;
            slot = SLOT_IN_W'(hot_base + $urandom_range(0, hot_count - 1));
            ts   = clock_s;
            if (r < 5)
            begin
                cmd  = 1'($urandom_range(0, 1));
                slot = SLOT_IN_W'($urandom_range(0, 255));
                ts   = $urandom;
            end
            else if (r < 10)
                cmd = CMD_RESET;
            else if (r < 15)
                ts = clock_s - $urandom_range(1, span + 1);
            r = $urandom_range(0, 9);
            if (r >= 9)
                clock_s += $urandom_range(0, span);
            else if (r >= 6)
                clock_s += 1;
            send_item(cmd, slot, ts);
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
                else
                    idle_for($urandom_range(1, 70));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(4, 12, 200);
        run_traffic(50, 60, 200);
        run_traffic(65535, 65535, 150);
        run_traffic(1, 1, 150);
        run_traffic(3, 0, 100);
        run_traffic($urandom_range(1, 300), $urandom_range(1, 600), 200);
        run_traffic(2, 65535, 100);
        run_traffic($urandom_range(1, 65535), $urandom_range(1, 65535), 100);
    endtask

    initial
    begin
        start     = 1'b0;
        command   = 1'b0;
        user_slot = '0;
        timestamp = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fresh_slot();
        test_reset_command();
        test_field_extremes();
        test_window_extremes();
        test_zero_capacity();
        test_capacity_lowered();
        test_unused_registers();
        test_random_traffic();

        wait_idle();
        repeat (60)
            @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tbrl_pkg.sv
rtl/core/tbrl_ctrl.sv
rtl/core/tbrl_datapath.sv
rtl/core/token_bucket_rate_limiter_core.sv
tb/tb_top.sv
